// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== sv/hrp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrp_pkg
// Shared types, constants and character-class functions of the request parser.
// ----------------------------------------------------------------------------
package hrp_pkg;

  localparam int VERB_BYTES_DEF    = 8;
  localparam int URI_BYTES_DEF     = 256;
  localparam int VERSION_BYTES_DEF = 16;
  localparam int LINE_BYTES_DEF    = 512;
  localparam int BODY_BYTES_DEF    = 4096;
  localparam int HDR_MATCH_LIMIT   = 512;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;

  localparam logic [2:0] ST_MORE = 3'd0;
  localparam logic [2:0] ST_GET  = 3'd1;
  localparam logic [2:0] ST_POST = 3'd2;
  localparam logic [2:0] ST_PUTD = 3'd3;
  localparam logic [2:0] ST_ERR  = 3'd4;

  localparam logic [2:0] VK_NONE = 3'd0;
  localparam logic [2:0] VK_GET  = 3'd1;
  localparam logic [2:0] VK_POST = 3'd2;
  localparam logic [2:0] VK_PUT  = 3'd3;
  localparam logic [2:0] VK_DEL  = 3'd4;

  localparam logic [1:0] DK_NONE = 2'd0;
  localparam logic [1:0] DK_URI  = 2'd1;
  localparam logic [1:0] DK_BODY = 2'd2;

  // Classified byte handed from front to back
  typedef struct packed {
    logic [7:0] lc;
    logic       restart;
    logic       is_upper;
    logic       is_uri;
    logic       is_ver;
    logic       is_digit;
    logic       is_ws;
    logic [7:0] raw;
  } cls_t;

  function automatic logic uri_char(input logic [7:0] c);
    logic r;
    r = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
        (c >= 8'h30 && c <= 8'h39);
    case (c)
      "?", "/", "%", ".", "_", "+", "-", ":", "#", "@", "$", "&", "=", ";",
      "~", "*": r = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic ver_char(input logic [7:0] c);
    return c == "H" || c == "T" || c == "P" || c == "/" || c == "0" ||
           c == "1" || c == ".";
  endfunction

  function automatic logic [7:0] len_pat(input logic [4:0] i);
    logic [7:0] r;
    case (i)
      5'd0: r = "c"; 5'd1: r = "o"; 5'd2: r = "n"; 5'd3: r = "t";
      5'd4: r = "e"; 5'd5: r = "n"; 5'd6: r = "t"; 5'd7: r = "-";
      5'd8: r = "l"; 5'd9: r = "e"; 5'd10: r = "n"; 5'd11: r = "g";
      5'd12: r = "t"; 5'd13: r = "h"; 5'd14: r = ":";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] keep_pat(input logic [4:0] i);
    logic [7:0] r;
    case (i)
      5'd0: r = "c"; 5'd1: r = "o"; 5'd2: r = "n"; 5'd3: r = "n";
      5'd4: r = "e"; 5'd5: r = "c"; 5'd6: r = "t"; 5'd7: r = "i";
      5'd8: r = "o"; 5'd9: r = "n"; 5'd10: r = ":"; 5'd11: r = " ";
      5'd12: r = "k"; 5'd13: r = "e"; 5'd14: r = "e"; 5'd15: r = "p";
      5'd16: r = "-"; 5'd17: r = "a"; 5'd18: r = "l"; 5'd19: r = "i";
      5'd20: r = "v"; 5'd21: r = "e";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/http_request_byte_parser.sv =====
// ----------------------------------------------------------------------------
// http_request_byte_parser
// HTTP/1.x request checker, one result per byte, URI and body streamed out.
// ----------------------------------------------------------------------------
// One byte is taken every cycle while the result side keeps up; each byte
// gives one result, held first in the classifier queue and then in the
// parser engine's output register. The phase machine and header matchers
// update once per byte, which sets that rate. No memory clearing is needed
// after reset.
module http_request_byte_parser import hrp_pkg::*; #(
  parameter int VERB_BYTES    = VERB_BYTES_DEF,
  parameter int URI_BYTES     = URI_BYTES_DEF,
  parameter int VERSION_BYTES = VERSION_BYTES_DEF,
  parameter int LINE_BYTES    = LINE_BYTES_DEF,
  parameter int BODY_BYTES    = BODY_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [2:0]  out_verb_kind,
  output logic [30:0] out_body_length,
  output logic        out_persistent,
  output logic [7:0]  out_data_byte,
  output logic [1:0]  out_data_kind
);
  logic q_wr, q_full, q_rd, q_nempty;
  cls_t q_wdata, q_rdata;

  hrp_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_byte_in, .in_restart,
    .q_wr, .q_data(q_wdata), .q_full
  );

  hrp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .wr(q_wr), .wdata(q_wdata), .full(q_full),
    .rd(q_rd), .rdata(q_rdata), .nempty(q_nempty)
  );

  hrp_engine #(
    .VERB_BYTES(VERB_BYTES), .URI_BYTES(URI_BYTES),
    .VERSION_BYTES(VERSION_BYTES), .LINE_BYTES(LINE_BYTES),
    .BODY_BYTES(BODY_BYTES)
  ) u_engine (
    .clk, .rst_n, .q_nempty, .q_data(q_rdata), .q_rd,
    .out_valid, .out_ready, .out_status, .out_verb_kind, .out_body_length,
    .out_persistent, .out_data_byte, .out_data_kind
  );
endmodule

// ===== sv/hrp_front.sv =====
// ----------------------------------------------------------------------------
// hrp_front
// Accepts request bytes, folds case and classifies each into a queue entry.
// ----------------------------------------------------------------------------
module hrp_front import hrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_in,
  input  logic       in_restart,
  output logic       q_wr,
  output cls_t       q_data,
  input  logic       q_full
);
  logic [7:0] lc;

  assign in_ready = !q_full;
  assign q_wr     = in_valid && !q_full;
  assign lc = (in_byte_in >= 8'h41 && in_byte_in <= 8'h5A) ? in_byte_in + 8'h20
                                                          : in_byte_in;

  always_comb begin
    q_data.raw      = in_byte_in;
    q_data.lc       = lc;
    q_data.restart  = in_restart;
    q_data.is_upper = in_byte_in >= 8'h41 && in_byte_in <= 8'h5A;
    q_data.is_uri   = uri_char(in_byte_in);
    q_data.is_ver   = ver_char(in_byte_in);
    q_data.is_digit = lc >= 8'h30 && lc <= 8'h39;
    q_data.is_ws    = lc == 8'h20 || lc == 8'h09 || lc == 8'h0B || lc == 8'h0C;
  end
endmodule

// ===== sv/hrp_queue.sv =====
// ----------------------------------------------------------------------------
// hrp_queue
// Short register queue between the classifier and the parser engine.
// ----------------------------------------------------------------------------
module hrp_queue import hrp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  cls_t wdata,
  output logic full,
  input  logic rd,
  output cls_t rdata,
  output logic nempty
);
  `include "assert_macros.svh"
  localparam int AW = $clog2(DEPTH);

  cls_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full   = cnt_r == (AW+1)'(DEPTH);
  assign nempty = cnt_r != '0;
  assign rdata  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  `ASSERT_IMPL(a_no_overflow, clk, rst_n, full, !wr, "queue written when full")
  `ASSERT_IMPL(a_no_underflow, clk, rst_n, !nempty, !rd, "queue read when empty")
endmodule

// ===== sv/hrp_engine.sv =====
// ----------------------------------------------------------------------------
// hrp_engine
// Request phase machine, header matchers and output register.
// ----------------------------------------------------------------------------
module hrp_engine import hrp_pkg::*; #(
  parameter int VERB_BYTES    = VERB_BYTES_DEF,
  parameter int URI_BYTES     = URI_BYTES_DEF,
  parameter int VERSION_BYTES = VERSION_BYTES_DEF,
  parameter int LINE_BYTES    = LINE_BYTES_DEF,
  parameter int BODY_BYTES    = BODY_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_nempty,
  input  cls_t        q_data,
  output logic        q_rd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [2:0]  out_verb_kind,
  output logic [30:0] out_body_length,
  output logic        out_persistent,
  output logic [7:0]  out_data_byte,
  output logic [1:0]  out_data_kind
);
  `include "assert_macros.svh"

  typedef enum logic [7:0] {
    PH_VERB = 8'b0000_0001, PH_URI = 8'b0000_0010, PH_VER = 8'b0000_0100,
    PH_LF1  = 8'b0000_1000, PH_HDR = 8'b0001_0000, PH_HLF = 8'b0010_0000,
    PH_BODY = 8'b0100_0000, PH_DONE = 8'b1000_0000
  } phase_t;

  localparam logic [4:0] LM_WS = 5'd15, LM_PLUS = 5'd16, LM_MINUS = 5'd17,
    LM_DIG_POS = 5'd18, LM_DIG_NEG = 5'd19, LM_END_POS = 5'd20,
    LM_END_NEG = 5'd21, KM_FULL = 5'd22, MATCH_DEAD = 5'd31;
  localparam logic [30:0] DIG_LIM = 31'd214748364;
  localparam int BCW = $clog2(BODY_BYTES + 1);
  // Line counter must reach the largest of the URI, line and header-match bounds
  localparam int LCMAX0 = (URI_BYTES > LINE_BYTES) ? URI_BYTES : LINE_BYTES;
  localparam int LCMAX  = (LCMAX0 > HDR_MATCH_LIMIT) ? LCMAX0 : HDR_MATCH_LIMIT;
  localparam int LCW    = $clog2(LCMAX + 1);

  phase_t      phase_r, phase_nxt;
  logic [LCW-1:0] line_r, line_nxt;
  logic [7:0]  verb_r [VERB_BYTES];
  logic [2:0]  method_r, method_nxt;
  logic [30:0] len_r, len_nxt, acc_r, acc_nxt;
  logic        keep_r, keep_nxt, err_r, err_nxt;
  logic [BCW-1:0] bc_r, bc_nxt;
  logic [4:0]  lm_r, lm_nxt, km_r, km_nxt;
  logic        vwr;

  // Effective state after an optional restart
  phase_t      ph;
  logic [LCW-1:0] lc0;
  logic [2:0]  me0;
  logic [30:0] le0, ac0;
  logic [BCW-1:0] bc0;
  logic [4:0]  lm0, km0;
  logic        er0, vclr;

  logic [2:0]  st;
  logic [1:0]  dk;
  logic        err;
  logic [2:0]  vcode;
  logic [3:0]  dgt;
  logic [30:0] acc_add;
  logic [7:0]  c, lc;

  logic        ov_r;
  logic        step;

  assign step  = q_nempty && (!ov_r || out_ready);
  assign q_rd  = step;
  assign c     = q_data.raw;
  assign lc    = q_data.lc;
  assign dgt   = lc[3:0];
  assign vclr  = q_data.restart;

  always_comb begin
    ph  = vclr ? PH_VERB : phase_r;
    lc0 = vclr ? '0 : line_r;
    me0 = vclr ? VK_NONE : method_r;
    le0 = vclr ? '0 : len_r;
    ac0 = vclr ? '0 : acc_r;
    bc0 = vclr ? '0 : bc_r;
    lm0 = vclr ? '0 : lm_r;
    km0 = vclr ? '0 : km_r;
    er0 = vclr ? 1'b0 : err_r;
  end

  function automatic logic vmatch(input logic [47:0] w, input int n);
    logic r;
    r = 1'b1;
    for (int i = 0; i < 6; i++)
      if (i < n && i < VERB_BYTES && verb_r[i] != w[47-8*i -: 8]) r = 1'b0;
    return r;
  endfunction

  always_comb begin
    vcode = VK_NONE;
    if (!vclr) begin
      if (lc0 == LCW'(3) && vmatch({"GET", 24'h0}, 3)) vcode = VK_GET;
      else if (lc0 == LCW'(4) && vmatch({"POST", 16'h0}, 4)) vcode = VK_POST;
      else if (lc0 == LCW'(3) && vmatch({"PUT", 24'h0}, 3)) vcode = VK_PUT;
      else if (lc0 == LCW'(6) && VERB_BYTES >= 6 && vmatch("DELETE", 6))
        vcode = VK_DEL;
    end
  end

  // Saturating decimal accumulate: ten times fits in 35 bits
  always_comb begin
    logic [34:0] t;
    t = {4'd0, ac0} * 35'd10 + {31'd0, dgt};
    acc_add = (ac0 > DIG_LIM || t > {4'd0, LEN_MAX}) ? LEN_MAX : t[30:0];
  end

  always_comb begin
    phase_nxt = ph; line_nxt = lc0; method_nxt = me0; len_nxt = le0;
    acc_nxt = ac0; keep_nxt = keep_r; bc_nxt = bc0; lm_nxt = lm0; km_nxt = km0;
    err = 1'b0; st = ST_MORE; dk = DK_NONE; vwr = 1'b0;
    if (!er0) begin
      case (ph)
        PH_VERB: begin
          if (lc0 >= LCW'(VERB_BYTES)) err = 1'b1;
          else if (q_data.is_upper) begin
            vwr = 1'b1; line_nxt = lc0 + LCW'(1);
          end else if (c == 8'h20) begin
            method_nxt = vcode; line_nxt = '0;
            if (vcode == VK_NONE) err = 1'b1; else phase_nxt = PH_URI;
          end else err = 1'b1;
        end
        PH_URI: begin
          if (32'(lc0) >= 32'(URI_BYTES)) err = 1'b1;
          else if (q_data.is_uri) begin
            line_nxt = lc0 + LCW'(1); dk = DK_URI;
          end else if (c == 8'h20) begin
            line_nxt = '0; phase_nxt = PH_VER;
          end else err = 1'b1;
        end
        PH_VER: begin
          if (lc0 >= LCW'(VERSION_BYTES)) err = 1'b1;
          else if (q_data.is_ver) line_nxt = lc0 + LCW'(1);
          else if (c == 8'h0D) begin
            line_nxt = '0; phase_nxt = PH_LF1;
          end else err = 1'b1;
        end
        PH_LF1: begin
          if (c == 8'h0A) begin
            line_nxt = '0; lm_nxt = '0; km_nxt = '0; acc_nxt = '0;
            phase_nxt = PH_HDR;
          end else err = 1'b1;
        end
        PH_HDR: begin
          if (32'(lc0) >= 32'(LINE_BYTES)) err = 1'b1;
          else if (c == 8'h0D) phase_nxt = PH_HLF;
          else if (c == 8'h0A) err = 1'b1;
          else begin
            line_nxt = lc0 + LCW'(1);
            if (lm0 < LM_WS) lm_nxt = (lc == len_pat(lm0)) ? lm0 + 5'd1 : MATCH_DEAD;
            else if (lm0 == LM_WS) begin
              if (q_data.is_ws) lm_nxt = LM_WS;
              else if (lc == "+") lm_nxt = LM_PLUS;
              else if (lc == "-") lm_nxt = LM_MINUS;
              else if (q_data.is_digit) begin
                acc_nxt = acc_add; lm_nxt = LM_DIG_POS;
              end else lm_nxt = MATCH_DEAD;
            end else if (lm0 == LM_PLUS || lm0 == LM_DIG_POS) begin
              if (q_data.is_digit) begin
                acc_nxt = acc_add; lm_nxt = LM_DIG_POS;
              end else lm_nxt = (lm0 == LM_PLUS) ? MATCH_DEAD : LM_END_POS;
            end else if (lm0 == LM_MINUS)
              lm_nxt = q_data.is_digit ? LM_DIG_NEG : MATCH_DEAD;
            else if (lm0 == LM_DIG_NEG)
              lm_nxt = q_data.is_digit ? LM_DIG_NEG : LM_END_NEG;
            if (km0 < KM_FULL) km_nxt = (lc == keep_pat(km0)) ? km0 + 5'd1 : MATCH_DEAD;
            else km_nxt = MATCH_DEAD;
          end
        end
        PH_HLF: begin
          if (c != 8'h0A) err = 1'b1;
          else if (lc0 != '0) begin
            if (32'(lc0) < HDR_MATCH_LIMIT) begin
              if (lm0 == LM_DIG_POS || lm0 == LM_END_POS) len_nxt = ac0;
              else if (lm0 == LM_DIG_NEG || lm0 == LM_END_NEG) len_nxt = '0;
              else if (km0 == KM_FULL) keep_nxt = 1'b1;
            end
            line_nxt = '0; lm_nxt = '0; km_nxt = '0; acc_nxt = '0;
            phase_nxt = PH_HDR;
          end else if (me0 == VK_GET) begin
            st = ST_GET; phase_nxt = PH_DONE;
          end else if (me0 == VK_POST) begin
            if (le0 != '0) begin
              bc_nxt = '0; phase_nxt = PH_BODY;
            end else begin
              st = ST_POST; phase_nxt = PH_DONE;
            end
          end else begin
            st = ST_PUTD; phase_nxt = PH_DONE;
          end
        end
        PH_BODY: begin
          if (le0 > 31'(BODY_BYTES) || 32'(bc0) >= 32'(BODY_BYTES)) err = 1'b1;
          else begin
            bc_nxt = bc0 + 1'b1; dk = DK_BODY;
            if (31'(bc_nxt) >= le0) begin
              st = ST_POST; phase_nxt = PH_DONE;
            end
          end
        end
        default: ;
      endcase
    end
    err_nxt = er0 || err;
    if (err_nxt) begin
      st = ST_ERR; dk = DK_NONE;
    end
  end

  // Letters beyond the stored count are never compared, so no clear is needed
  always_ff @(posedge clk) begin
    if (step && vwr) verb_r[lc0[$clog2(VERB_BYTES)-1:0]] <= c;
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_status      <= st;
      out_verb_kind   <= method_nxt;
      out_body_length <= len_nxt;
      out_persistent  <= keep_nxt;
      out_data_byte   <= (dk == DK_NONE) ? 8'h00 : c;
      out_data_kind   <= dk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_VERB; line_r <= '0; method_r <= VK_NONE; len_r <= '0;
      acc_r <= '0; keep_r <= 1'b0; err_r <= 1'b0; bc_r <= '0; lm_r <= '0;
      km_r <= '0; ov_r <= 1'b0;
    end else begin
      if (step) begin
        phase_r <= phase_nxt; line_r <= line_nxt; method_r <= method_nxt;
        len_r <= len_nxt; acc_r <= acc_nxt; keep_r <= keep_nxt;
        err_r <= err_nxt; bc_r <= bc_nxt; lm_r <= lm_nxt; km_r <= km_nxt;
      end
      if (step) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  assign out_valid = ov_r;

  `ASSERT_NEXT(a_err_sticky, clk, rst_n, err_r && !(step && vclr), err_r,
    "error cleared without restart")
  `ASSERT_IMPL(a_err_status, clk, rst_n, out_valid && out_status == ST_ERR,
    out_data_kind == DK_NONE, "data passed with error status")
  `ASSERT_IMPL(a_done_quiet, clk, rst_n, phase_r == PH_DONE && !err_r,
    out_data_kind == DK_NONE || !out_valid || out_status != ST_MORE,
    "data after completion")
endmodule
